[design/ssme_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted store min/max extract package
// Shared constants, codes and link types for the sorted cell chain.
// ----------------------------------------------------------------------------
package ssme_pkg;

    localparam int DEPTH   = 1024;
    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 2'd0,
        OP_LOAD     = 2'd1,
        OP_TAKE_MAX = 2'd2,
        OP_TAKE_MIN = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_CLEAR,
        CMD_INSERT,
        CMD_POP_HEAD,
        CMD_DROP_TAIL
    } cell_cmd_t;

    typedef struct packed {
        logic                      valid;
        logic                      after;
        logic signed [VALUE_W-1:0] value;
    } cell_link_t;

endpackage

[design/ssme_if.sv]
// ----------------------------------------------------------------------------
// Sorted store min/max extract channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ssme_req_if;

    logic                                    valid;
    logic                                    ready;
    logic [ssme_pkg::OP_W-1:0]               op;
    logic signed [ssme_pkg::VALUE_W-1:0]     value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);

endinterface

interface ssme_rsp_if;

    logic                                    valid;
    logic                                    ready;
    logic signed [ssme_pkg::VALUE_W-1:0]     result_value;
    logic [ssme_pkg::STAT_W-1:0]             status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);

endinterface

[design/ssme_cell.sv]
// ----------------------------------------------------------------------------
// Sorted store cell
// Holds one value of the ascending chain and moves it to or from a neighbor.
// ----------------------------------------------------------------------------
module ssme_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ssme_pkg::cell_cmd_t                 cmd,
    input  logic signed [ssme_pkg::VALUE_W-1:0] ins_value,
    input  ssme_pkg::cell_link_t                prev,
    input  ssme_pkg::cell_link_t                next,
    output ssme_pkg::cell_link_t                link
);

    logic                                valid_reg;
    logic                                valid_next;
    logic signed [ssme_pkg::VALUE_W-1:0] value_reg;
    logic signed [ssme_pkg::VALUE_W-1:0] value_next;
    logic                                after;

    // An empty cell or one holding a larger value lies after the new value.
    assign after = !valid_reg || (value_reg > ins_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        case (cmd)
            ssme_pkg::CMD_HOLD:
            begin
                valid_next = valid_reg;
            end
            ssme_pkg::CMD_CLEAR:
            begin
                valid_next = 1'b0;
            end
            ssme_pkg::CMD_INSERT:
            begin
                valid_next = valid_reg || prev.valid;
                if (prev.after)
                begin
                    value_next = prev.value;
                end
                else if (after)
                begin
                    value_next = ins_value;
                end
            end
            ssme_pkg::CMD_POP_HEAD:
            begin
                valid_next = next.valid;
                value_next = next.value;
            end
            ssme_pkg::CMD_DROP_TAIL:
            begin
                valid_next = valid_reg && next.valid;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.after = after;
    assign link.value = value_reg;

endmodule

[design/ssme_chain.sv]
// ----------------------------------------------------------------------------
// Sorted store cell chain
// A row of cells kept in ascending order from the head cell upward.
// ----------------------------------------------------------------------------
module ssme_chain (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ssme_pkg::cell_cmd_t                 cmd,
    input  logic signed [ssme_pkg::VALUE_W-1:0] ins_value,
    output ssme_pkg::cell_link_t                head,
    output logic                                tail_valid
);

    ssme_pkg::cell_link_t links [ssme_pkg::DEPTH];

    for (genvar i = 0; i < ssme_pkg::DEPTH; i++)
    begin : g_cell
        ssme_pkg::cell_link_t prev_link;
        ssme_pkg::cell_link_t next_link;

        if (i == 0)
        begin : g_head
            assign prev_link.valid = 1'b1;
            assign prev_link.after = 1'b0;
            assign prev_link.value = '0;
        end
        else
        begin : g_body
            assign prev_link = links[i-1];
        end

        if (i == ssme_pkg::DEPTH - 1)
        begin : g_top
            assign next_link.valid = 1'b0;
            assign next_link.after = 1'b1;
            assign next_link.value = '0;
        end
        else
        begin : g_below
            assign next_link = links[i+1];
        end

        ssme_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .ins_value (ins_value),
            .prev      (prev_link),
            .next      (next_link),
            .link      (links[i])
        );
    end

    assign head       = links[0];
    assign tail_valid = links[ssme_pkg::DEPTH-1].valid;

endmodule

[design/sorted_store_min_max_extract_unit.sv]
// ----------------------------------------------------------------------------
// Sorted store min/max extract unit
// Double-ended priority queue built from two sorted cell chains.
// ----------------------------------------------------------------------------
// A result is registered and shows in the cycle after its request is accepted.
// Throughput: one request per cycle unless a held result stalls; every cell
// updates in the same cycle. The output register frees as soon as its result
// is taken. Reset empties both chains at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_store_min_max_extract_unit (
    input  logic              clk,
    input  logic              rst_n,
    ssme_req_if.sink          req,
    ssme_rsp_if.source        rsp
);

    ssme_pkg::cell_cmd_t                 cmd_lo;
    ssme_pkg::cell_cmd_t                 cmd_hi;
    ssme_pkg::cell_link_t                head_lo;
    ssme_pkg::cell_link_t                head_hi;
    logic                                tail_lo_valid;
    logic                                tail_hi_valid;
    logic                                accept;
    logic                                empty;
    logic                                full;
    ssme_pkg::op_t                       op;
    logic signed [ssme_pkg::VALUE_W-1:0] ins_hi;

    logic                                rsp_valid_reg;
    logic                                rsp_valid_next;
    logic signed [ssme_pkg::VALUE_W-1:0] result_value_reg;
    logic signed [ssme_pkg::VALUE_W-1:0] result_value_next;
    ssme_pkg::status_t                   status_reg;
    ssme_pkg::status_t                   status_next;
    logic                                emit;

    // The upper chain keeps inverted values, so its head is the largest value.
    assign op     = ssme_pkg::op_t'(req.op);
    assign ins_hi = ~req.value;
    assign accept = req.valid && req.ready;
    assign empty  = !head_lo.valid;
    assign full   = tail_lo_valid && tail_hi_valid;

    always_comb
    begin
        cmd_lo            = ssme_pkg::CMD_HOLD;
        cmd_hi            = ssme_pkg::CMD_HOLD;
        emit              = 1'b0;
        result_value_next = '0;
        status_next       = ssme_pkg::ST_OK;
        if (accept)
        begin
            case (op)
                ssme_pkg::OP_CLEAR:
                begin
                    cmd_lo = ssme_pkg::CMD_CLEAR;
                    cmd_hi = ssme_pkg::CMD_CLEAR;
                end
                ssme_pkg::OP_LOAD:
                begin
                    if (full)
                    begin
                        emit        = 1'b1;
                        status_next = ssme_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd_lo = ssme_pkg::CMD_INSERT;
                        cmd_hi = ssme_pkg::CMD_INSERT;
                    end
                end
                ssme_pkg::OP_TAKE_MAX:
                begin
                    emit = 1'b1;
                    if (empty)
                    begin
                        status_next = ssme_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd_lo            = ssme_pkg::CMD_DROP_TAIL;
                        cmd_hi            = ssme_pkg::CMD_POP_HEAD;
                        result_value_next = ~head_hi.value;
                    end
                end
                ssme_pkg::OP_TAKE_MIN:
                begin
                    emit = 1'b1;
                    if (empty)
                    begin
                        status_next = ssme_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd_lo            = ssme_pkg::CMD_POP_HEAD;
                        cmd_hi            = ssme_pkg::CMD_DROP_TAIL;
                        result_value_next = head_lo.value;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign rsp_valid_next = emit || (rsp_valid_reg && !rsp.ready);
    assign req.ready      = !rsp_valid_reg || rsp.ready;

    ssme_chain u_chain_lo (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_lo),
        .ins_value  (req.value),
        .head       (head_lo),
        .tail_valid (tail_lo_valid)
    );

    ssme_chain u_chain_hi (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_hi),
        .ins_value  (ins_hi),
        .head       (head_hi),
        .tail_valid (tail_hi_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_value_reg <= result_value_next;
            status_reg       <= status_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = result_value_reg;
    assign rsp.status       = status_reg;

endmodule

[design/ssme_checker.sv]
// ----------------------------------------------------------------------------
// Sorted store min/max extract checker
// Port-level properties of the unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ssme_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_ready,
    input  logic [ssme_pkg::OP_W-1:0]           req_op,
    input  logic signed [ssme_pkg::VALUE_W-1:0] req_value,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic signed [ssme_pkg::VALUE_W-1:0] rsp_result_value,
    input  logic [ssme_pkg::STAT_W-1:0]         rsp_status
);

    logic acc;

    assign acc = req_valid && req_ready;

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ssme_pkg::ST_OK) |-> rsp_result_value == '0)
        else $error("error result carries a nonzero value");

    a_take_answers: assert property (@(posedge clk) disable iff (!rst_n)
        acc && ((req_op == ssme_pkg::OP_TAKE_MAX) || (req_op == ssme_pkg::OP_TAKE_MIN))
        |=> rsp_valid)
        else $error("take request produced no result");

    a_clear_then_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (req_op == ssme_pkg::OP_CLEAR)) ##1
        (acc && ((req_op == ssme_pkg::OP_TAKE_MAX) || (req_op == ssme_pkg::OP_TAKE_MIN)))
        |=> rsp_valid && (rsp_status == ssme_pkg::ST_EMPTY))
        else $error("take after clear did not report an empty set");

    a_single_value: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (req_op == ssme_pkg::OP_CLEAR)) ##1
        (acc && (req_op == ssme_pkg::OP_LOAD)) ##1
        (acc && (req_op == ssme_pkg::OP_TAKE_MAX))
        |=> rsp_valid && (rsp_status == ssme_pkg::ST_OK) &&
            (rsp_result_value == $past(req_value, 2)))
        else $error("single loaded value not returned by take");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) &&
            $stable(rsp_status))
        else $error("stalled result changed");

endmodule

bind sorted_store_min_max_extract_unit ssme_checker u_ssme_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_op           (req.op),
    .req_value        (req.value),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_value (rsp.result_value),
    .rsp_status       (rsp.status)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Sorted store min/max extract testbench
// Sends a short table of directed requests and then long random sequences:
// small working sets, a full fill with refill from the low end, and noise.
// Results are checked against the table or a sorted-queue predictor, with random gaps
// on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb;

    import ssme_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_OFF   = 200;
    localparam int DIR_N      = 23;
    localparam int PRINT_CAP  = 40;

    typedef logic signed [VALUE_W-1:0] word_t;

    typedef struct packed {
        op_t     op;
        word_t   value;
        logic    fixed_want;
        word_t   want_value;
        status_t want_status;
    } request_row_t;

    typedef struct packed {
        word_t   value;
        status_t status;
    } outcome_t;

    localparam request_row_t DIRECTED [DIR_N] = '{
        '{OP_TAKE_MAX, 32'sh0000_0000, 1'b1, 32'sh0000_0000, ST_EMPTY},
        '{OP_TAKE_MIN, 32'shFFFF_FFFF, 1'b1, 32'sh0000_0000, ST_EMPTY},
        '{OP_LOAD,     32'sh7FFF_FFFF, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_LOAD,     32'sh8000_0000, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_LOAD,     32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_LOAD,     32'shFFFF_FFFF, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_LOAD,     32'sh0000_0001, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_TAKE_MAX, 32'sh0000_0000, 1'b1, 32'sh7FFF_FFFF, ST_OK},
        '{OP_TAKE_MIN, 32'sh0000_0000, 1'b1, 32'sh8000_0000, ST_OK},
        '{OP_LOAD,     32'sh0000_0005, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_LOAD,     32'sh0000_0005, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_LOAD,     32'shFFFF_FFFB, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_TAKE_MAX, 32'sh0000_0000, 1'b1, 32'sh0000_0005, ST_OK},
        '{OP_TAKE_MAX, 32'sh7FFF_FFFF, 1'b1, 32'sh0000_0005, ST_OK},
        '{OP_TAKE_MIN, 32'sh0000_0000, 1'b1, 32'shFFFF_FFFB, ST_OK},
        '{OP_TAKE_MIN, 32'sh1234_5678, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_CLEAR,    32'shFFFF_FFFF, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_TAKE_MIN, 32'sh0000_0000, 1'b1, 32'sh0000_0000, ST_EMPTY},
        '{OP_LOAD,     32'sh5555_5555, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_LOAD,     32'shAAAA_AAAA, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_TAKE_MAX, 32'sh0F0F_0F0F, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_CLEAR,    32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK},
        '{OP_TAKE_MAX, 32'sh0000_0000, 1'b1, 32'sh0000_0000, ST_EMPTY}
    };

    logic clk = 1'b0;
    logic rst_n;

    ssme_req_if req_ch ();
    ssme_rsp_if rsp_ch ();

    sorted_store_min_max_extract_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    word_t    held_values[$];
    outcome_t pending_results[$];

    int  error_count   = 0;
    int  sent_count    = 0;
    int  checked_count = 0;
    int  empty_count   = 0;
    int  full_count    = 0;
    int  peak_fill     = 0;
    bit  steady        = 1'b0;
    bit  hold_request  = 1'b0;

    function automatic int draw_pause();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(6, 25);
        end
    endfunction

    function automatic word_t draw_value();
        int r;
        begin
            r = $urandom_range(0, 99);
            case (r % 4)
                0: if (r < 12) return 32'sh8000_0000;
                1: if (r < 12) return 32'sh7FFF_FFFF;
                2: if (r < 12) return 32'sh0000_0000;
                default: if (r < 12) return 32'shFFFF_FFFF;
            endcase
            if (r < 35)
                return word_t'($urandom_range(0, 15)) - 32'sd8;
            return word_t'($urandom);
        end
    endfunction

    function automatic request_row_t make_row(input op_t op, input word_t value);
        request_row_t row;
        begin
            row             = '0;
            row.op          = op;
            row.value       = value;
            row.want_status = ST_OK;
            return row;
        end
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        begin
            if (error_count < PRINT_CAP)
                $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
            error_count++;
        end
    endtask

    task automatic predict_request(input op_t op, input word_t value,
                                   output logic produced, output outcome_t res);
        int p;
        begin
            produced   = 1'b0;
            res.value  = '0;
            res.status = ST_OK;
            case (op)
                OP_CLEAR:
                    held_values.delete();
                OP_LOAD:
                    if (held_values.size() >= DEPTH)
                    begin
                        produced   = 1'b1;
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        p = 0;
                        while (p < held_values.size() && held_values[p] <= value)
                            p++;
                        held_values.insert(p, value);
                    end
                default:
                    if (held_values.size() == 0)
                    begin
                        produced   = 1'b1;
                        res.status = ST_EMPTY;
                    end
                    else if (op == OP_TAKE_MAX)
                    begin
                        produced  = 1'b1;
                        res.value = held_values.pop_back();
                    end
                    else
                    begin
                        produced  = 1'b1;
                        res.value = held_values.pop_front();
                    end
            endcase
            if (held_values.size() > peak_fill)
                peak_fill = held_values.size();
        end
    endtask

    task automatic offer_request(input request_row_t row);
        int       pause;
        logic     produced;
        outcome_t res;
        begin
            pause = steady ? 0 : draw_pause();
            if (pause > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (pause) @(negedge clk);
            end
            req_ch.valid = 1'b1;
            req_ch.op    = row.op;
            req_ch.value = row.value;
            @(posedge clk);
            while (!req_ch.ready)
                @(posedge clk);
            predict_request(row.op, row.value, produced, res);
            if (produced)
            begin
                if (row.fixed_want)
                begin
                    res.value  = row.want_value;
                    res.status = row.want_status;
                end
                pending_results.push_back(res);
            end
            sent_count++;
            @(negedge clk);
        end
    endtask

    task automatic offer_mixed(input int count, input int load_pct, input int clear_pct);
        int   r;
        op_t  op;
        begin
            repeat (count)
            begin
                r = $urandom_range(0, 99);
                if (r < clear_pct)
                    op = OP_CLEAR;
                else if (r < clear_pct + load_pct)
                    op = OP_LOAD;
                else if (r[0])
                    op = OP_TAKE_MAX;
                else
                    op = OP_TAKE_MIN;
                offer_request(make_row(op, draw_value()));
            end
        end
    endtask

    // Result side: random stalls, occasional stall-free stretches, and one long hold-off.
    initial
    begin
        int  stall_left;
        int  tick;
        bit  rx_steady;
        stall_left   = 0;
        tick         = 0;
        rx_steady    = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 64 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_OFF - 1;
                rsp_ch.ready = 1'b0;
            end
            else if (rx_steady)
            begin
                rsp_ch.ready = 1'b1;
            end
            else
            begin
                stall_left   = draw_pause();
                rsp_ch.ready = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin
        outcome_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result", rsp_ch.result_value, '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (want.status == ST_EMPTY)
                        empty_count++;
                    if (want.status == ST_FULL)
                        full_count++;
                    if (rsp_ch.result_value !== want.value)
                        report_mismatch("result_value", rsp_ch.result_value, want.value);
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", word_t'(rsp_ch.status), word_t'(want.status));
                end
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        wait (rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        int i;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_CLEAR;
        req_ch.value = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_N; i++)
            offer_request(DIRECTED[i]);

        for (i = 0; i < 6; i++)
        begin
            steady = ($urandom_range(0, 3) == 0);
            offer_mixed(50, 52, 3);
        end

        // The result side holds off while takes keep coming, so the output register fills and requests stall.
        steady       = 1'b1;
        hold_request = 1'b1;
        repeat (10) offer_request(make_row(OP_LOAD, draw_value()));
        repeat (40) offer_request(make_row($urandom_range(0, 1) ? OP_TAKE_MAX : OP_TAKE_MIN,
                                           draw_value()));

        // Fill to capacity, overflow, then refill from the low end of the window.
        steady = 1'b0;
        offer_request(make_row(OP_CLEAR, draw_value()));
        while (held_values.size() < DEPTH)
            offer_request(make_row(OP_LOAD, draw_value()));
        repeat (3) offer_request(make_row(OP_LOAD, draw_value()));
        repeat (6) offer_request(make_row(OP_TAKE_MIN, draw_value()));
        repeat (8) offer_request(make_row(OP_LOAD, draw_value()));
        repeat (3) offer_request(make_row(OP_TAKE_MAX, draw_value()));
        repeat (2) offer_request(make_row(OP_LOAD, draw_value()));
        offer_mixed(100, 30, 0);

        offer_mixed(200, 25, 25);

        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Summary: %0d requests sent, %0d results checked (%0d empty, %0d full).",
                 sent_count, checked_count, empty_count, full_count);
        $display("Summary: peak fill %0d of %0d values, with overflow and low-end refill.",
                 peak_fill, DEPTH);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
